// ----- rtl/iss_pkg.sv -----
package iss_pkg;

  localparam int unsigned DefaultCapacity = 64;
  localparam logic [31:0] ErrData = 32'h7FFF_FFFF;
  localparam logic [6:0]  NonePos = 7'h7F;

  typedef enum logic [3:0] {
    KIND_PUSH_FRONT   = 4'd0,
    KIND_PUSH_BACK    = 4'd1,
    KIND_POP_FRONT    = 4'd2,
    KIND_POP_BACK     = 4'd3,
    KIND_INSERT       = 4'd4,
    KIND_ERASE        = 4'd5,
    KIND_READ_AT      = 4'd6,
    KIND_READ_END     = 4'd7,
    KIND_FIND         = 4'd8,
    KIND_REMOVE_VALUE = 4'd9,
    KIND_REVERSE      = 4'd10,
    KIND_PEEK_FRONT   = 4'd11,
    KIND_PEEK_BACK    = 4'd12
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GAP,
    S_GAP_WR,
    S_CLOSE_RD,
    S_CLOSE_CAP,
    S_CLOSE,
    S_CLOSE_WR,
    S_READ_RD,
    S_READ_CAP,
    S_FIND,
    S_FIND_CMP,
    S_REV,
    S_REV_RDJ,
    S_REV_WRI,
    S_REV_WRJ,
    S_DONE
  } state_e;

endpackage

// ----- rtl/indexed_sequence_store.sv -----
// Ordered store of up to CAPACITY signed 32-bit values with push/pop at both
// ends, insert/erase at an index, indexed reads, first-match find/remove,
// reverse and peeks. One transaction is handled at a time: in_stall_o stays
// high from acceptance until the result transaction is taken. All element
// moves go through one single-port-write, registered-read memory under a
// small sequencer, one element moved or searched at a time (one swapped
// pair at a time for reverse). Reads and peeks fetch a single element, while
// push front, insert, erase, front pops, find, remove and reverse step through
// the elements on that memory port. No clearing pass.
module indexed_sequence_store #(
  parameter int unsigned CAPACITY = iss_pkg::DefaultCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  kind_i,
  input  logic [5:0]  position_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] data_o,
  output logic [6:0]  found_at_o,
  output logic [6:0]  count_o,
  output logic        is_empty_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  iss_pkg::state_e  state_q, state_d;
  iss_pkg::status_e status_q, status_d;
  logic [31:0]   data_q, data_d;
  logic [6:0]    found_q, found_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] jdx_q, jdx_d;
  logic [CW-1:0] at_q, at_d;
  logic [31:0]   val_q, val_d;
  logic [31:0]   tmp_q, tmp_d;
  logic          remove_q, remove_d;

  // element memory
  logic [31:0]   mem_q [CAPACITY];
  logic [31:0]   rdata_q;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic          we;

  logic          in_accept;
  logic          pos_ge_count;

  assign in_accept    = in_valid_i && (state_q == iss_pkg::S_IDLE);
  assign pos_ge_count = 32'(position_i) >= 32'(count_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iss_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    data_q   <= data_d;
    found_q  <= found_d;
    idx_q    <= idx_d;
    jdx_q    <= jdx_d;
    at_q     <= at_d;
    val_q    <= val_d;
    tmp_q    <= tmp_d;
    remove_q <= remove_d;
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    data_d   = data_q;
    found_d  = found_q;
    count_d  = count_q;
    idx_d    = idx_q;
    jdx_d    = jdx_q;
    at_d     = at_q;
    val_d    = val_q;
    tmp_d    = tmp_q;
    remove_d = remove_q;
    raddr    = idx_q[AW-1:0];
    waddr    = idx_q[AW-1:0];
    wdata    = rdata_q;
    we       = 1'b0;
    unique case (state_q)
      iss_pkg::S_IDLE: begin
        if (in_accept) begin
          status_d = iss_pkg::ST_OK;
          data_d   = '0;
          found_d  = iss_pkg::NonePos;
          val_d    = value_i;
          remove_d = 1'b0;
          state_d  = iss_pkg::S_DONE;
          case (iss_pkg::kind_e'(kind_i))
            iss_pkg::KIND_PUSH_FRONT, iss_pkg::KIND_PUSH_BACK, iss_pkg::KIND_INSERT: begin
              if (count_q == CapCount) begin
                status_d = iss_pkg::ST_FULL;
              end else if (kind_i == iss_pkg::KIND_INSERT && pos_ge_count) begin
                status_d = iss_pkg::ST_RANGE;
              end else begin
                idx_d   = count_q;
                state_d = iss_pkg::S_GAP;
                if (kind_i == iss_pkg::KIND_PUSH_FRONT) begin
                  at_d = '0;
                end else if (kind_i == iss_pkg::KIND_PUSH_BACK) begin
                  at_d = count_q;
                end else begin
                  at_d = CW'(position_i);
                end
              end
            end
            iss_pkg::KIND_POP_FRONT, iss_pkg::KIND_POP_BACK: begin
              if (count_q == '0) begin
                status_d = iss_pkg::ST_EMPTY;
              end else begin
                idx_d   = (kind_i == iss_pkg::KIND_POP_FRONT) ? '0 : count_q - 1'b1;
                state_d = iss_pkg::S_CLOSE_RD;
              end
            end
            iss_pkg::KIND_ERASE: begin
              if (pos_ge_count) begin
                status_d = iss_pkg::ST_RANGE;
              end else begin
                idx_d   = CW'(position_i);
                state_d = iss_pkg::S_CLOSE_RD;
              end
            end
            iss_pkg::KIND_READ_AT: begin
              if (count_q == '0) begin
                status_d = iss_pkg::ST_EMPTY;
              end else if (pos_ge_count) begin
                status_d = iss_pkg::ST_RANGE;
              end else begin
                idx_d   = CW'(position_i);
                state_d = iss_pkg::S_READ_RD;
              end
            end
            iss_pkg::KIND_READ_END: begin
              if (pos_ge_count) begin
                status_d = iss_pkg::ST_RANGE;
              end else begin
                idx_d   = count_q - CW'(position_i) - 1'b1;
                state_d = iss_pkg::S_READ_RD;
              end
            end
            iss_pkg::KIND_FIND, iss_pkg::KIND_REMOVE_VALUE: begin
              idx_d    = '0;
              remove_d = (kind_i == iss_pkg::KIND_REMOVE_VALUE);
              state_d  = iss_pkg::S_FIND;
            end
            iss_pkg::KIND_REVERSE: begin
              if (count_q >= CW'(2)) begin
                idx_d   = '0;
                jdx_d   = count_q - 1'b1;
                state_d = iss_pkg::S_REV;
              end
            end
            iss_pkg::KIND_PEEK_FRONT, iss_pkg::KIND_PEEK_BACK: begin
              if (count_q == '0) begin
                status_d = iss_pkg::ST_EMPTY;
              end else begin
                idx_d   = (kind_i == iss_pkg::KIND_PEEK_FRONT) ? '0 : count_q - 1'b1;
                state_d = iss_pkg::S_READ_RD;
              end
            end
            default: ;
          endcase
          if (status_d != iss_pkg::ST_OK) begin
            data_d = iss_pkg::ErrData;
          end
        end
      end
      // open a gap at at_q, moving the tail up by one
      iss_pkg::S_GAP: begin
        if (idx_q > at_q) begin
          raddr   = AW'(idx_q - 1'b1);
          state_d = iss_pkg::S_GAP_WR;
        end else begin
          we      = 1'b1;
          waddr   = at_q[AW-1:0];
          wdata   = val_q;
          count_d = count_q + 1'b1;
          state_d = iss_pkg::S_DONE;
        end
      end
      iss_pkg::S_GAP_WR: begin
        we      = 1'b1;
        idx_d   = idx_q - 1'b1;
        state_d = iss_pkg::S_GAP;
      end
      // close the gap at idx_q, returning the removed value
      iss_pkg::S_CLOSE_RD: begin
        state_d = iss_pkg::S_CLOSE_CAP;
      end
      iss_pkg::S_CLOSE_CAP: begin
        data_d  = rdata_q;
        state_d = iss_pkg::S_CLOSE;
      end
      iss_pkg::S_CLOSE: begin
        if (32'(idx_q) + 32'd1 < 32'(count_q)) begin
          raddr   = AW'(idx_q + 1'b1);
          state_d = iss_pkg::S_CLOSE_WR;
        end else begin
          count_d = count_q - 1'b1;
          state_d = iss_pkg::S_DONE;
        end
      end
      iss_pkg::S_CLOSE_WR: begin
        we      = 1'b1;
        idx_d   = idx_q + 1'b1;
        state_d = iss_pkg::S_CLOSE;
      end
      // single element read
      iss_pkg::S_READ_RD: begin
        state_d = iss_pkg::S_READ_CAP;
      end
      iss_pkg::S_READ_CAP: begin
        data_d  = rdata_q;
        state_d = iss_pkg::S_DONE;
      end
      // linear search for the first match
      iss_pkg::S_FIND: begin
        if (idx_q < count_q) begin
          state_d = iss_pkg::S_FIND_CMP;
        end else begin
          status_d = iss_pkg::ST_NOTFOUND;
          data_d   = iss_pkg::ErrData;
          state_d  = iss_pkg::S_DONE;
        end
      end
      iss_pkg::S_FIND_CMP: begin
        if (rdata_q == val_q) begin
          found_d = 7'(idx_q);
          data_d  = rdata_q;
          state_d = remove_q ? iss_pkg::S_CLOSE : iss_pkg::S_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = iss_pkg::S_FIND;
        end
      end
      // swap pairs from both ends toward the middle
      iss_pkg::S_REV: begin
        if (idx_q < jdx_q) begin
          state_d = iss_pkg::S_REV_RDJ;
        end else begin
          state_d = iss_pkg::S_DONE;
        end
      end
      iss_pkg::S_REV_RDJ: begin
        tmp_d   = rdata_q;
        raddr   = jdx_q[AW-1:0];
        state_d = iss_pkg::S_REV_WRI;
      end
      iss_pkg::S_REV_WRI: begin
        we      = 1'b1;
        state_d = iss_pkg::S_REV_WRJ;
      end
      iss_pkg::S_REV_WRJ: begin
        we      = 1'b1;
        waddr   = jdx_q[AW-1:0];
        wdata   = tmp_q;
        idx_d   = idx_q + 1'b1;
        jdx_d   = jdx_q - 1'b1;
        state_d = iss_pkg::S_REV;
      end
      // hold the result until the transaction is taken
      iss_pkg::S_DONE: begin
        if (!out_stall_i) begin
          state_d = iss_pkg::S_IDLE;
        end
      end
      default: state_d = iss_pkg::S_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != iss_pkg::S_IDLE);
  assign out_valid_o = (state_q == iss_pkg::S_DONE);
  assign status_o    = status_q;
  assign data_o      = data_q;
  assign found_at_o  = found_q;
  assign count_o     = 7'(count_q);
  assign is_empty_o  = (count_q == '0);

endmodule

// ----- rtl/iss_checker.sv -----
module iss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [31:0] data_o,
  input logic [6:0]  found_at_o,
  input logic [6:0]  count_o,
  input logic        is_empty_o
);

  // no new transaction while a result is pending
  a_busy_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");

  // error results carry the error data word
  a_err_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != iss_pkg::ST_OK) |-> (data_o == iss_pkg::ErrData))
    else $error("error status without error data");

  // a found position only comes with an ok status
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_at_o != iss_pkg::NonePos) |-> (status_o == iss_pkg::ST_OK))
    else $error("found position on failed transaction");

  // empty flag agrees with count
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_empty_o |-> (count_o == 7'd0)) else $error("empty flag with nonzero count");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(data_o) && $stable(status_o)))
    else $error("stalled result changed");

endmodule

bind indexed_sequence_store iss_checker u_iss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .data_o      (data_o),
  .found_at_o  (found_at_o),
  .count_o     (count_o),
  .is_empty_o  (is_empty_o)
);
